@@ hdl/sdd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sdd_pkg
// Shared types, codes and constants of the serpentine error diffusion dither.
// ============================================================================
package sdd_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_PALETTE_SIZE = 16;
    localparam int DEF_ERROR_BITS   = 12;

    // Register reset values.
    localparam logic [7:0]  RST_STRENGTH = 8'd100;
    localparam logic [10:0] RST_WIDTH    = 11'd1024;
    localparam logic [4:0]  RST_COUNT    = 5'd16;
    localparam logic [4:0]  RST_TRANS    = 5'd16;

    // Division by 100 for values below 2^16: (x * 83887) >> 23.
    localparam logic [16:0] RECIP_100   = 17'd83887;
    localparam int          RECIP_SHIFT = 23;

    // Channel widths fixed by the word format.
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_PIXEL   = 2'd1,
        OP_PALETTE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_STRENGTH = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_COUNT    = 2'd2,
        CFG_TRANS    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_CLR_ALL,
        S_IDLE,
        S_CLR_NEXT,
        S_READ,
        S_VAL,
        S_SEARCH,
        S_PICK,
        S_SCALE,
        S_SHARE,
        S_RMW_RD,
        S_RMW_WR,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch_in;
        logic       pal_write;
        logic       swap;
        logic       last_row_zero;
        logic       clr_start;
        logic       clr_all;
        logic       clr_next;
        logic       err_read;
        logic       val_load;
        logic       srch_step;
        logic       pick;
        logic       scale;
        logic       share;
        logic       rmw_wr;
        logic [1:0] rmw_step;
        logic       emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic col_ok;
        logic row_change;
        logic clr_last;
        logic srch_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

@@ hdl/sdd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sdd_if
// Valid/ready channels for pixel words and result words.
// ============================================================================
interface sdd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  pixel_luma;
    logic [7:0]  pixel_alpha;
    logic [9:0]  pixel_column;
    logic [15:0] pixel_row;

    modport source (output valid, op, pixel_luma, pixel_alpha, pixel_column, pixel_row,
                    input ready);
    modport sink   (input valid, op, pixel_luma, pixel_alpha, pixel_column, pixel_row,
                    output ready);
endinterface

interface sdd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] palette_index;
    logic [7:0] out_luma;
    logic [7:0] out_alpha;

    modport source (output valid, palette_index, out_luma, out_alpha, input ready);
    modport sink   (input valid, palette_index, out_luma, out_alpha, output ready);
endinterface
`default_nettype wire

@@ hdl/sdd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sdd_ctrl
// Sequencer: clearing sweeps, palette search, error scaling and write-back.
// ============================================================================
module sdd_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire sdd_pkg::sts_t sts,
    output sdd_pkg::cmd_t      cmd
);

    sdd_pkg::state_t state_reg, state_next;
    logic [1:0]      step_reg, step_next;
    logic            fire;

    assign in_ready = (state_reg == sdd_pkg::S_IDLE);
    assign fire     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdd_pkg::S_CLR_ALL;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            sdd_pkg::S_CLR_ALL:
                if (sts.clr_last) state_next = sdd_pkg::S_IDLE;
            sdd_pkg::S_IDLE:
                if (fire)
                begin
                    case (sts.op)
                        sdd_pkg::OP_START: state_next = sdd_pkg::S_CLR_ALL;
                        sdd_pkg::OP_PIXEL:
                            if (sts.col_ok)
                                state_next = sts.row_change ? sdd_pkg::S_CLR_NEXT
                                                            : sdd_pkg::S_READ;
                        default: state_next = sdd_pkg::S_IDLE;
                    endcase
                end
            sdd_pkg::S_CLR_NEXT:
                if (sts.clr_last) state_next = sdd_pkg::S_READ;
            sdd_pkg::S_READ:   state_next = sdd_pkg::S_VAL;
            sdd_pkg::S_VAL:    state_next = sdd_pkg::S_SEARCH;
            sdd_pkg::S_SEARCH:
                if (sts.srch_last) state_next = sdd_pkg::S_PICK;
            sdd_pkg::S_PICK:   state_next = sdd_pkg::S_SCALE;
            sdd_pkg::S_SCALE:  state_next = sdd_pkg::S_SHARE;
            sdd_pkg::S_SHARE:
            begin
                state_next = sdd_pkg::S_RMW_RD;
                step_next  = 2'd0;
            end
            sdd_pkg::S_RMW_RD: state_next = sdd_pkg::S_RMW_WR;
            sdd_pkg::S_RMW_WR:
            begin
                step_next  = step_reg + 2'd1;
                state_next = (step_reg == 2'd3) ? sdd_pkg::S_EMIT : sdd_pkg::S_RMW_RD;
            end
            sdd_pkg::S_EMIT:
                if (sts.out_free) state_next = sdd_pkg::S_IDLE;
            default: state_next = sdd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd               = '0;
        cmd.rmw_step      = step_reg;
        cmd.latch_in      = fire;
        cmd.pal_write     = fire && (sts.op == sdd_pkg::OP_PALETTE);
        cmd.last_row_zero = fire && (sts.op == sdd_pkg::OP_START);
        cmd.swap          = fire && (sts.op == sdd_pkg::OP_PIXEL) && sts.col_ok
                            && sts.row_change;
        cmd.clr_start     = cmd.last_row_zero || cmd.swap;
        case (state_reg)
            sdd_pkg::S_CLR_ALL:  cmd.clr_all   = 1'b1;
            sdd_pkg::S_CLR_NEXT: cmd.clr_next  = 1'b1;
            sdd_pkg::S_READ:     cmd.err_read  = 1'b1;
            sdd_pkg::S_VAL:      cmd.val_load  = 1'b1;
            sdd_pkg::S_SEARCH:   cmd.srch_step = 1'b1;
            sdd_pkg::S_PICK:     cmd.pick      = 1'b1;
            sdd_pkg::S_SCALE:    cmd.scale     = 1'b1;
            sdd_pkg::S_SHARE:    cmd.share     = 1'b1;
            sdd_pkg::S_RMW_WR:   cmd.rmw_wr    = 1'b1;
            sdd_pkg::S_EMIT:     cmd.emit      = sts.out_free;
            default:             cmd.emit      = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded while output register is still full");
    a_swap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.swap |=> state_reg == sdd_pkg::S_CLR_NEXT)
        else $error("row change not followed by clearing of the next line");
    a_search_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdd_pkg::S_SEARCH && sts.srch_last) |=> state_reg == sdd_pkg::S_PICK)
        else $error("search did not end on its last entry");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdd_pkg::S_EMIT && !sts.out_free) |=> state_reg == sdd_pkg::S_EMIT)
        else $error("result dropped while output stalled");
`endif

endmodule
`default_nettype wire

@@ hdl/sdd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sdd_datapath
// Error line banks, palette table, nearest-entry search and error diffusion.
// ============================================================================
module sdd_datapath
#(
    parameter int MAX_WIDTH    = sdd_pkg::DEF_MAX_WIDTH,
    parameter int PALETTE_SIZE = sdd_pkg::DEF_PALETTE_SIZE,
    parameter int ERROR_BITS   = sdd_pkg::DEF_ERROR_BITS
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire sdd_pkg::cmd_t                  cmd,
    output sdd_pkg::sts_t                       sts,
    input  wire logic                           cfg_write_en,
    input  wire logic [sdd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sdd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]                     in_op,
    input  wire logic [7:0]                     in_luma,
    input  wire logic [7:0]                     in_alpha,
    input  wire logic [9:0]                     in_column,
    input  wire logic [15:0]                    in_row,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output logic [3:0]                          res_index,
    output logic [7:0]                          res_luma,
    output logic [7:0]                          res_alpha
);

    localparam int LINE_SLOTS = MAX_WIDTH + 2;
    localparam int AW         = $clog2(LINE_SLOTS);
    localparam int IW         = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int EB         = ERROR_BITS;
    localparam logic signed [EB:0] ERR_HI = (EB+1)'(2**(EB-1) - 1);
    localparam logic signed [EB:0] ERR_LO = (EB+1)'(-(2**(EB-1)));

    // Configuration registers.
    logic [7:0]  strength_reg;
    logic [10:0] width_reg;
    logic [4:0]  count_reg;
    logic [4:0]  trans_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= sdd_pkg::RST_STRENGTH;
            width_reg    <= sdd_pkg::RST_WIDTH;
            count_reg    <= sdd_pkg::RST_COUNT;
            trans_reg    <= sdd_pkg::RST_TRANS;
        end
        else if (cfg_write_en)
        begin
            case (sdd_pkg::cfg_idx_t'(cfg_index))
                sdd_pkg::CFG_STRENGTH: strength_reg <= cfg_data[7:0];
                sdd_pkg::CFG_WIDTH:    width_reg    <= cfg_data;
                sdd_pkg::CFG_COUNT:    count_reg    <= cfg_data[4:0];
                sdd_pkg::CFG_TRANS:    trans_reg    <= cfg_data[4:0];
                default:               strength_reg <= strength_reg;
            endcase
        end
    end

    // Effective width and search length.
    logic [15:0] eff_width;
    logic [8:0]  eff_count;
    logic [IW-1:0] last_idx;

    always_comb
    begin
        if (width_reg == 11'd0)
            eff_width = 16'd1;
        else if (16'(width_reg) > 16'(MAX_WIDTH))
            eff_width = 16'(MAX_WIDTH);
        else
            eff_width = 16'(width_reg);
        if (count_reg == 5'd0)
            eff_count = 9'd1;
        else if (9'(count_reg) > 9'(PALETTE_SIZE))
            eff_count = 9'(PALETTE_SIZE);
        else
            eff_count = 9'(count_reg);
    end
    assign last_idx = IW'(eff_count - 9'd1);

    // Row tracking and bank selection.
    logic [15:0] last_row_reg;
    logic        cb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_row_reg <= 16'd0;
            cb_reg       <= 1'b0;
        end
        else if (cmd.last_row_zero)
            last_row_reg <= 16'd0;
        else if (cmd.swap)
        begin
            last_row_reg <= in_row;
            cb_reg       <= ~cb_reg;
        end
    end

    // Latched pixel.
    logic [7:0] luma_reg;
    logic [7:0] alpha_reg;
    logic [9:0] col_reg;
    logic       odd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            luma_reg  <= in_luma;
            alpha_reg <= in_alpha;
            col_reg   <= in_column;
            odd_reg   <= in_row[0];
        end
    end

    // Clearing sweep counter.
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr_start)
            clr_cnt_reg <= '0;
        else if (cmd.clr_all || cmd.clr_next)
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
    end

    // Error line banks; each word holds luma error over alpha error.
    logic [2*EB-1:0] bank0_mem [LINE_SLOTS];
    logic [2*EB-1:0] bank1_mem [LINE_SLOTS];
    logic [2*EB-1:0] rd0_q, rd1_q, data_cur, data_next, old_word, wr_word;
    logic [AW-1:0]   c0, c1, c2, rmw_addr, rd_addr, wr_addr;
    logic            we0, we1, clearing, tgt_bank;

    assign c0 = AW'(col_reg);
    assign c1 = c0 + AW'(1);
    assign c2 = c0 + AW'(2);

    always_comb
    begin
        case (cmd.rmw_step)
            2'd0:    rmw_addr = odd_reg ? c0 : c2;
            2'd1:    rmw_addr = odd_reg ? c2 : c0;
            2'd2:    rmw_addr = c1;
            default: rmw_addr = odd_reg ? c0 : c2;
        endcase
    end

    assign clearing  = cmd.clr_all || cmd.clr_next;
    assign rd_addr   = cmd.err_read ? c1 : rmw_addr;
    assign wr_addr   = clearing ? clr_cnt_reg : rmw_addr;
    assign tgt_bank  = (cmd.rmw_step == 2'd0) ? cb_reg : ~cb_reg;
    assign we0       = cmd.clr_all || (cmd.clr_next && cb_reg)
                       || (cmd.rmw_wr && !tgt_bank);
    assign we1       = cmd.clr_all || (cmd.clr_next && !cb_reg)
                       || (cmd.rmw_wr && tgt_bank);
    assign data_cur  = cb_reg ? rd1_q : rd0_q;
    assign data_next = cb_reg ? rd0_q : rd1_q;
    assign old_word  = (cmd.rmw_step == 2'd0) ? data_cur : data_next;

    always_ff @(posedge clk)
    begin
        if (we0)
            bank0_mem[wr_addr] <= wr_word;
        rd0_q <= bank0_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
            bank1_mem[wr_addr] <= wr_word;
        rd1_q <= bank1_mem[rd_addr];
    end

    // Pixel plus stored error, clamped to a byte.
    logic signed [EB+1:0] t_l, t_a;
    logic [7:0]           v_l_reg, v_a_reg;

    assign t_l = $signed((EB+2)'(luma_reg))
                 + (EB+2)'($signed(data_cur[2*EB-1:EB]));
    assign t_a = $signed((EB+2)'(alpha_reg)) + (EB+2)'($signed(data_cur[EB-1:0]));

    always_ff @(posedge clk)
    begin
        if (cmd.val_load)
        begin
            v_l_reg <= (t_l < 0) ? 8'd0 : ((t_l > 255) ? 8'd255 : t_l[7:0]);
            v_a_reg <= (t_a < 0) ? 8'd0 : ((t_a > 255) ? 8'd255 : t_a[7:0]);
        end
    end

    // Palette table and nearest-entry search.
    logic [15:0]        pal_mem [PALETTE_SIZE];
    logic [15:0]        pal_q;
    logic [IW-1:0]      pal_rd_addr, srch_idx_reg, best_reg, best_next;
    logic [17:0]        best_dist_reg, sq_dist;
    logic signed [9:0]  dl, da;
    logic signed [19:0] dl_sq, da_sq;
    logic               closer;

    always_ff @(posedge clk)
    begin
        if (cmd.pal_write && (in_column < 10'(PALETTE_SIZE)))
            pal_mem[IW'(in_column)] <= {in_luma, in_alpha};
        pal_q <= pal_mem[pal_rd_addr];
    end

    assign dl        = $signed({2'b00, v_l_reg}) - $signed({2'b00, pal_q[15:8]});
    assign da        = $signed({2'b00, v_a_reg}) - $signed({2'b00, pal_q[7:0]});
    assign dl_sq     = dl * dl;
    assign da_sq     = da * da;
    assign sq_dist   = {1'b0, dl_sq[16:0]} + {1'b0, da_sq[16:0]};
    assign closer    = sq_dist < best_dist_reg;
    assign best_next = closer ? srch_idx_reg : best_reg;

    always_comb
    begin
        if (!cmd.srch_step)
            pal_rd_addr = '0;
        else if (srch_idx_reg == last_idx)
            pal_rd_addr = best_next;
        else
            pal_rd_addr = srch_idx_reg + IW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.val_load)
        begin
            srch_idx_reg  <= '0;
            best_reg      <= '0;
            best_dist_reg <= '1;
        end
        else if (cmd.srch_step)
        begin
            srch_idx_reg <= srch_idx_reg + IW'(1);
            best_reg     <= best_next;
            if (closer)
                best_dist_reg <= sq_dist;
        end
    end

    // Quantization error times strength; kept as sign and magnitude.
    logic               is_trans;
    logic [7:0]         ch_l, ch_a;
    logic signed [9:0]  df_l, df_a;
    logic signed [18:0] p_l, p_a;
    logic [15:0]        pm_l_reg, pm_a_reg;
    logic               neg_l_reg, neg_a_reg;
    logic [3:0]         pick_idx_reg;
    logic [7:0]         pick_luma_reg, pick_alpha_reg;

    assign is_trans = (9'(best_reg) == 9'(trans_reg)) || (pal_q[7:0] == 8'd0);
    assign ch_l     = is_trans ? luma_reg : pal_q[15:8];
    assign ch_a     = is_trans ? 8'd0 : pal_q[7:0];
    assign df_l     = $signed({2'b00, v_l_reg}) - $signed({2'b00, ch_l});
    assign df_a     = $signed({2'b00, v_a_reg}) - $signed({2'b00, ch_a});
    assign p_l      = 19'(df_l) * $signed({11'd0, strength_reg});
    assign p_a      = 19'(df_a) * $signed({11'd0, strength_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            neg_l_reg      <= p_l[18];
            neg_a_reg      <= p_a[18];
            pm_l_reg       <= p_l[18] ? 16'(-p_l) : p_l[15:0];
            pm_a_reg       <= p_a[18] ? 16'(-p_a) : p_a[15:0];
            pick_idx_reg   <= 4'(best_reg);
            pick_luma_reg  <= pal_q[15:8];
            pick_alpha_reg <= pal_q[7:0];
        end
    end

    // Divide by 100 through the reciprocal.
    logic [32:0] prod_l, prod_a;
    logic [9:0]  q_l_reg, q_a_reg;

    assign prod_l = {17'd0, pm_l_reg} * 33'(sdd_pkg::RECIP_100);
    assign prod_a = {17'd0, pm_a_reg} * 33'(sdd_pkg::RECIP_100);

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            q_l_reg <= prod_l[sdd_pkg::RECIP_SHIFT +: 10];
            q_a_reg <= prod_a[sdd_pkg::RECIP_SHIFT +: 10];
        end
    end

    // Shares in step order: forward 7/16, then 3/16, 5/16, 1/16 on the next line.
    logic [12:0]       m7_l, m3_l, m5_l, m7_a, m3_a, m5_a;
    logic signed [9:0] dlt_l_reg [4];
    logic signed [9:0] dlt_a_reg [4];

    assign m7_l = 13'(q_l_reg) * 13'd7;
    assign m3_l = 13'(q_l_reg) * 13'd3;
    assign m5_l = 13'(q_l_reg) * 13'd5;
    assign m7_a = 13'(q_a_reg) * 13'd7;
    assign m3_a = 13'(q_a_reg) * 13'd3;
    assign m5_a = 13'(q_a_reg) * 13'd5;

    always_ff @(posedge clk)
    begin
        if (cmd.share)
        begin
            dlt_l_reg[0] <= neg_l_reg ? -10'(m7_l[12:4]) : 10'(m7_l[12:4]);
            dlt_l_reg[1] <= neg_l_reg ? -10'(m3_l[12:4]) : 10'(m3_l[12:4]);
            dlt_l_reg[2] <= neg_l_reg ? -10'(m5_l[12:4]) : 10'(m5_l[12:4]);
            dlt_l_reg[3] <= neg_l_reg ? -10'(q_l_reg[9:4]) : 10'(q_l_reg[9:4]);
            dlt_a_reg[0] <= neg_a_reg ? -10'(m7_a[12:4]) : 10'(m7_a[12:4]);
            dlt_a_reg[1] <= neg_a_reg ? -10'(m3_a[12:4]) : 10'(m3_a[12:4]);
            dlt_a_reg[2] <= neg_a_reg ? -10'(m5_a[12:4]) : 10'(m5_a[12:4]);
            dlt_a_reg[3] <= neg_a_reg ? -10'(q_a_reg[9:4]) : 10'(q_a_reg[9:4]);
        end
    end

    // Saturating accumulate into the addressed error word.
    logic signed [EB:0]   sum_l, sum_a;
    logic signed [EB-1:0] sat_l, sat_a;

    assign sum_l = (EB+1)'($signed(old_word[2*EB-1:EB])) + (EB+1)'(dlt_l_reg[cmd.rmw_step]);
    assign sum_a = (EB+1)'($signed(old_word[EB-1:0])) + (EB+1)'(dlt_a_reg[cmd.rmw_step]);
    assign sat_l = (sum_l > ERR_HI) ? EB'(ERR_HI) : ((sum_l < ERR_LO) ? EB'(ERR_LO)
                                                                       : EB'(sum_l));
    assign sat_a = (sum_a > ERR_HI) ? EB'(ERR_HI) : ((sum_a < ERR_LO) ? EB'(ERR_LO)
                                                                       : EB'(sum_a));
    assign wr_word = clearing ? '0 : {sat_l, sat_a};

    // Output register.
    logic       out_valid_reg;
    logic [3:0] out_idx_reg;
    logic [7:0] out_luma_reg, out_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_idx_reg   <= pick_idx_reg;
            out_luma_reg  <= pick_luma_reg;
            out_alpha_reg <= pick_alpha_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_index = out_idx_reg;
    assign res_luma  = out_luma_reg;
    assign res_alpha = out_alpha_reg;

    // Status.
    assign sts.op         = sdd_pkg::op_t'(in_op);
    assign sts.col_ok     = 16'(in_column) < eff_width;
    assign sts.row_change = in_row != last_row_reg;
    assign sts.clr_last   = clr_cnt_reg == AW'(LINE_SLOTS - 1);
    assign sts.srch_last  = srch_idx_reg == last_idx;
    assign sts.out_free   = !out_valid_reg || res_ready;

endmodule
`default_nettype wire

@@ hdl/serpentine_error_diffusion_dither_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// serpentine_error_diffusion_dither_core
// Serpentine Floyd-Steinberg dither of luma-plus-alpha pixels to a palette.
// ============================================================================
//
//  Channel   Dir  Handshake      Word
//  pixel     in   valid/ready    op, pixel_luma, pixel_alpha, pixel_column, pixel_row
//  result    out  valid/ready    palette_index, out_luma, out_alpha
//  cfg       in   cfg_write_en   cfg_index, cfg_data (no stall)
//
//  A pixel word is searched over the first palette_count entries (count taken as
//  1 to PALETTE_SIZE): the palette search reads one entry per cycle from the
//  palette table, then four read-modify-write passes go through the error line
//  banks. After reset, and after a start-frame word, a clearing pass over all
//  MAX_WIDTH + 2 slots zeroes both error lines; no word is taken meanwhile.
//  The first pixel of a new row first clears the next line's MAX_WIDTH + 2 slots.
//  Palette writes and ignored words return straight to idle. A finished result
//  waits in the output register; only the next result waits for it to drain.
//
module serpentine_error_diffusion_dither_core
#(
    parameter int MAX_WIDTH    = sdd_pkg::DEF_MAX_WIDTH,
    parameter int PALETTE_SIZE = sdd_pkg::DEF_PALETTE_SIZE,
    parameter int ERROR_BITS   = sdd_pkg::DEF_ERROR_BITS
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    sdd_in_if.sink                              pixel,
    sdd_out_if.source                           result,
    input  wire logic                           cfg_write_en,
    input  wire logic [sdd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sdd_pkg::CFG_DATA_W-1:0] cfg_data
);

    sdd_pkg::cmd_t cmd;
    sdd_pkg::sts_t sts;
    logic          in_ready;

    // The controller owns the input handshake; the datapath owns the output register.
    assign pixel.ready = in_ready;

    sdd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdd_datapath
    #(
        .MAX_WIDTH    (MAX_WIDTH),
        .PALETTE_SIZE (PALETTE_SIZE),
        .ERROR_BITS   (ERROR_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_op        (pixel.op),
        .in_luma      (pixel.pixel_luma),
        .in_alpha     (pixel.pixel_alpha),
        .in_column    (pixel.pixel_column),
        .in_row       (pixel.pixel_row),
        .res_valid    (result.valid),
        .res_ready    (result.ready),
        .res_index    (result.palette_index),
        .res_luma     (result.out_luma),
        .res_alpha    (result.out_alpha)
    );

endmodule
`default_nettype wire

@@ test/tb_serpentine_error_diffusion_dither_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_serpentine_error_diffusion_dither_core
// Self-checking bench for the serpentine error diffusion dither core.
// A directed table loads the palette and probes the corner cases. Serpentine
// frames with random content and some noise words follow. Every result word
// is compared against a cycle-free software copy of the dither.
// ============================================================================
module tb_serpentine_error_diffusion_dither_core;
    import sdd_pkg::*;

    localparam int MAXW      = 1024;
    localparam int SLOTS     = MAXW + 2;
    localparam int PAL_N     = 16;
    localparam int ERR_HI    = 2047;
    localparam int ERR_LO    = -2048;
    localparam int N_WORDS   = 1650;
    localparam int N_PHASES  = 8;
    localparam int SETTLE    = 1200;   // a clearing pass plus margin
    localparam int DOG_LIMIT = 12000;  // cycles with no word moving on either side

    typedef struct {
        op_t         op;
        logic [7:0]  luma;
        logic [7:0]  alpha;
        logic [9:0]  col;
        logic [15:0] row;
    } pix_word_t;

    typedef struct {
        logic [3:0] idx;
        logic [7:0] luma;
        logic [7:0] alpha;
    } dither_word_t;

    // A directed row: the pixel word plus, where it is obvious, the result.
    typedef struct {
        pix_word_t    w;
        bit           typed;
        dither_word_t res;
    } probe_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sdd_in_if  pix ();
    sdd_out_if res ();

    serpentine_error_diffusion_dither_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pix.sink),
        .result       (res.source),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Software copy of the block state.
    int          err_cur [2][SLOTS];
    int          err_nxt [2][SLOTS];
    logic [7:0]  pal_luma [PAL_N];
    logic [7:0]  pal_alpha [PAL_N];
    logic [15:0] row_seen;
    int          strength;
    int          width_reg;
    int          count_reg;
    int          trans_reg;

    dither_word_t pending_dither[$];

    int  errors;
    int  cycle;
    int  last_move;
    int  results_seen;
    bit  calm;        // set for the tail of the run: no idling at all
    bit  stim_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int sat_err(input int s);
        if (s > ERR_HI) return ERR_HI;
        if (s < ERR_LO) return ERR_LO;
        return s;
    endfunction

    function automatic int clamp8(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic void wipe_lines();
        for (int c = 0; c < 2; c++)
            for (int s = 0; s < SLOTS; s++)
            begin
                err_cur[c][s] = 0;
                err_nxt[c][s] = 0;
            end
    endfunction

    // Works out what one accepted pixel word does to the state, and queues
    // the result word that it yields, if any. Returns 1 when a result is due.
    function automatic bit dither_word(input pix_word_t w);
        int eff_w;
        int cnt;
        int best;
        int best_d;
        int d;
        int dl;
        int da;
        int v [2];
        int pick [2];
        int src [2];
        int q;
        dither_word_t r;

        case (w.op)
            OP_START:
            begin
                wipe_lines();
                row_seen = '0;
                return 1'b0;
            end
            OP_PALETTE:
            begin
                if (w.col < PAL_N)
                begin
                    pal_luma[w.col]  = w.luma;
                    pal_alpha[w.col] = w.alpha;
                end
                return 1'b0;
            end
            OP_PIXEL: ;
            default: return 1'b0;
        endcase

        eff_w = (width_reg == 0) ? 1 : width_reg;
        if (eff_w > MAXW) eff_w = MAXW;
        if (w.col >= eff_w) return 1'b0;

        // A new row promotes the next error line and starts a fresh one.
        if (w.row != row_seen)
        begin
            for (int c = 0; c < 2; c++)
                for (int s = 0; s < SLOTS; s++)
                begin
                    err_cur[c][s] = err_nxt[c][s];
                    err_nxt[c][s] = 0;
                end
            row_seen = w.row;
        end

        src[0] = w.luma;
        src[1] = w.alpha;
        v[0] = clamp8(src[0] + err_cur[0][w.col + 1]);
        v[1] = clamp8(src[1] + err_cur[1][w.col + 1]);

        cnt = (count_reg == 0) ? 1 : count_reg;
        if (cnt > PAL_N) cnt = PAL_N;
        best   = 0;
        best_d = 32'h7fffffff;
        for (int i = 0; i < cnt; i++)
        begin
            dl = v[0] - int'(pal_luma[i]);
            da = v[1] - int'(pal_alpha[i]);
            d  = dl * dl + da * da;
            // Strict compare keeps the lowest index on a tie.
            if (d < best_d)
            begin
                best_d = d;
                best   = i;
            end
        end

        pick[0] = pal_luma[best];
        pick[1] = pal_alpha[best];
        // A transparent pick keeps the source luma and counts as alpha 0.
        if (best == trans_reg || pick[1] == 0)
        begin
            pick[0] = src[0];
            pick[1] = 0;
        end

        for (int c = 0; c < 2; c++)
        begin
            q = (v[c] - pick[c]) * strength / 100;
            if (w.row[0])
            begin
                err_cur[c][w.col]     = sat_err(err_cur[c][w.col] + q * 7 / 16);
                err_nxt[c][w.col + 2] = sat_err(err_nxt[c][w.col + 2] + q * 3 / 16);
                err_nxt[c][w.col + 1] = sat_err(err_nxt[c][w.col + 1] + q * 5 / 16);
                err_nxt[c][w.col]     = sat_err(err_nxt[c][w.col] + q / 16);
            end
            else
            begin
                err_cur[c][w.col + 2] = sat_err(err_cur[c][w.col + 2] + q * 7 / 16);
                err_nxt[c][w.col]     = sat_err(err_nxt[c][w.col] + q * 3 / 16);
                err_nxt[c][w.col + 1] = sat_err(err_nxt[c][w.col + 1] + q * 5 / 16);
                err_nxt[c][w.col + 2] = sat_err(err_nxt[c][w.col + 2] + q / 16);
            end
        end

        r.idx   = best[3:0];
        r.luma  = pal_luma[best];
        r.alpha = pal_alpha[best];
        pending_dither.push_back(r);
        return 1'b1;
    endfunction

    // Offers one word and returns once it has been taken. The valid line is
    // left high so that a following word goes out back to back; every other
    // path lowers it in the same time step as the acceptance.
    task automatic send_word(input pix_word_t w, output bit yields);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        pix.valid        <= 1'b1;
        pix.op           <= w.op;
        pix.pixel_luma   <= w.luma;
        pix.pixel_alpha  <= w.alpha;
        pix.pixel_column <= w.col;
        pix.pixel_row    <= w.row;
        do
            @(posedge clk);
        while (!pix.ready);
        last_move = cycle;
        yields = dither_word(w);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_STRENGTH: strength  = value & 8'hff;
            CFG_WIDTH:    width_reg = value & 11'h7ff;
            CFG_COUNT:    count_reg = value & 5'h1f;
            default:      trans_reg = value & 5'h1f;
        endcase
    endtask

    // Waits until the block has drained and is idle, then loads a setting.
    task automatic reconfigure(input int s, input int w, input int c, input int t);
        pix.valid <= 1'b0;
        while (pending_dither.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        last_move = cycle;
        write_reg(CFG_STRENGTH, s);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_COUNT, c);
        write_reg(CFG_TRANS, t);
    endtask

    function automatic pix_word_t make_word(input op_t op, input int l, input int a,
                                            input int c, input int r);
        pix_word_t w;
        w.op    = op;
        w.luma  = l[7:0];
        w.alpha = a[7:0];
        w.col   = c[9:0];
        w.row   = r[15:0];
        return w;
    endfunction

    function automatic probe_t probe(input pix_word_t w, input bit typed,
                                     input int i, input int l, input int a);
        probe_t p;
        p.w         = w;
        p.typed     = typed;
        p.res.idx   = i[3:0];
        p.res.luma  = l[7:0];
        p.res.alpha = a[7:0];
        return p;
    endfunction

    // Watchdog: a long spell with no word moving on either channel means a hang.
    initial
    begin
        cycle     = 0;
        last_move = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle - last_move > DOG_LIMIT)
            begin
                $display("%0t: watchdog, nothing moved for %0d cycles", $time, DOG_LIMIT);
                $display("tb_serpentine_error_diffusion_dither_core: errors");
                $finish;
            end
        end
    end

    // Result side: checks each taken word, then picks the next ready level.
    // Once, early on, ready stays low for a long stretch so that the output
    // register fills and the block stalls its pixel input behind it.
    initial
    begin : result_side
        int           stall_left;
        bit           held;
        dither_word_t exp_w;

        stall_left   = 0;
        held         = 1'b0;
        results_seen = 0;
        res.ready    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                last_move = cycle;
                results_seen++;
                if (pending_dither.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word idx %0d luma %0d alpha %0d",
                             $time, res.palette_index, res.out_luma, res.out_alpha);
                end
                else
                begin
                    exp_w = pending_dither.pop_front();
                    if (res.palette_index !== exp_w.idx)
                    begin
                        errors++;
                        $display("%0t: palette_index expected %0d actual %0d",
                                 $time, exp_w.idx, res.palette_index);
                    end
                    if (res.out_luma !== exp_w.luma)
                    begin
                        errors++;
                        $display("%0t: out_luma expected %0d actual %0d",
                                 $time, exp_w.luma, res.out_luma);
                    end
                    if (res.out_alpha !== exp_w.alpha)
                    begin
                        errors++;
                        $display("%0t: out_alpha expected %0d actual %0d",
                                 $time, exp_w.alpha, res.out_alpha);
                    end
                end
            end
            if (!held && results_seen == 60)
            begin
                held       = 1'b1;
                stall_left = 500;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= 1'b1;
            end
        end
    end

    // Pixel side and run control.
    initial
    begin : pixel_side
        probe_t    probes[$];
        pix_word_t w;
        bit        yields;
        int        counted;
        int        per_phase;
        int        eff_w;
        int        len;
        int        cur_row;
        int        phase_cfg [N_PHASES][4];

        errors       = 0;
        calm         = 1'b0;
        stim_done    = 1'b0;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        pix.valid        = 1'b0;
        pix.op           = OP_NONE;
        pix.pixel_luma   = '0;
        pix.pixel_alpha  = '0;
        pix.pixel_column = '0;
        pix.pixel_row    = '0;

        strength  = RST_STRENGTH;
        width_reg = RST_WIDTH;
        count_reg = RST_COUNT;
        trans_reg = RST_TRANS;
        row_seen  = '0;
        wipe_lines();
        for (int i = 0; i < PAL_N; i++)
        begin
            pal_luma[i]  = '0;
            pal_alpha[i] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The whole palette is loaded before any pixel, so no search ever
        // touches an entry that was never written. Entry i is (17i, 17i):
        // entry 0 is black and see-through, entry 15 is full white.
        for (int i = 0; i < PAL_N; i++)
            probes.push_back(probe(make_word(OP_PALETTE, 17 * i, 17 * i, i, 0), 0, 0, 0, 0));
        // Exact hits on the first row leave no error behind.
        probes.push_back(probe(make_word(OP_PIXEL, 0, 0, 0, 0), 1, 0, 0, 0));
        probes.push_back(probe(make_word(OP_PIXEL, 255, 255, 1, 0), 1, 15, 255, 255));
        probes.push_back(probe(make_word(OP_PIXEL, 100, 37, 2, 0), 0, 0, 0, 0));
        probes.push_back(probe(make_word(OP_PIXEL, 255, 0, 1023, 0), 0, 0, 0, 0));
        // An unknown op and a palette slot past the table are both dropped.
        probes.push_back(probe(make_word(OP_NONE, 255, 255, 1023, 65535), 0, 0, 0, 0));
        probes.push_back(probe(make_word(OP_PALETTE, 255, 255, 1023, 0), 0, 0, 0, 0));
        // Odd row, walked right to left, after a row change.
        probes.push_back(probe(make_word(OP_PIXEL, 200, 90, 1023, 1), 0, 0, 0, 0));
        probes.push_back(probe(make_word(OP_PIXEL, 13, 250, 1022, 1), 0, 0, 0, 0));
        // A start of frame clears the error lines: the exact hit comes back.
        probes.push_back(probe(make_word(OP_START, 0, 0, 0, 0), 0, 0, 0, 0));
        probes.push_back(probe(make_word(OP_PIXEL, 0, 0, 0, 0), 1, 0, 0, 0));
        probes.push_back(probe(make_word(OP_PIXEL, 128, 200, 5, 65535), 0, 0, 0, 0));

        foreach (probes[k])
        begin
            send_word(probes[k].w, yields);
            if (yields && probes[k].typed)
            begin
                void'(pending_dither.pop_back());
                pending_dither.push_back(probes[k].res);
            end
        end

        // Settings walked by the random part: strength, width, count,
        // transparent index. A zero count and out-of-range values exercise the
        // clamping of width and count.
        phase_cfg = '{
            '{100, 6, 16, 16},
            '{0, 1, 1, 0},
            '{200, 8, 16, 16},
            '{200, 2047, 31, 31},
            '{37, 5, 0, 3},
            '{150, 1024, 16, 0},
            '{73, 3, 9, 16},
            '{100, 7, 16, 5}
        };

        counted   = 0;
        per_phase = N_WORDS / N_PHASES;
        for (int p = 0; p < N_PHASES; p++)
        begin
            reconfigure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            eff_w = (width_reg == 0) ? 1 : width_reg;
            if (eff_w > MAXW) eff_w = MAXW;
            send_word(make_word(OP_START, 0, 0, 0, 0), yields);
            cur_row = 0;
            while (counted < per_phase * (p + 1))
            begin
                // One serpentine row, at most 8 pixels long on wide images.
                len = (eff_w < 8) ? eff_w : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                begin
                    if (counted > N_WORDS - 150) calm = 1'b1;
                    if ($urandom_range(0, 6) == 0)
                    begin
                        // Noise: any op, any column, any row.
                        w = make_word(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                                      $urandom_range(0, 255), $urandom_range(0, 1023),
                                      $urandom_range(0, 65535));
                        if (w.op == OP_START) cur_row = 0;
                        send_word(w, yields);
                        if (w.op == OP_PALETTE || w.op == OP_START || yields) counted++;
                    end
                    w = make_word(OP_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                                  cur_row[0] ? eff_w - 1 - k : k, cur_row);
                    send_word(w, yields);
                    counted++;
                end
                cur_row++;
                if ($urandom_range(0, 24) == 0)
                begin
                    send_word(make_word(OP_START, 0, 0, 0, 0), yields);
                    cur_row = 0;
                end
            end
        end

        pix.valid <= 1'b0;
        stim_done = 1'b1;
        while (pending_dither.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (errors == 0)
            $display("tb_serpentine_error_diffusion_dither_core: clean");
        else
            $display("tb_serpentine_error_diffusion_dither_core: errors");
        $finish;
    end

endmodule

@@ serpentine_error_diffusion_dither_core.f @@
hdl/sdd_pkg.sv
hdl/sdd_if.sv
hdl/sdd_ctrl.sv
hdl/sdd_datapath.sv
hdl/serpentine_error_diffusion_dither_core.sv
test/tb_serpentine_error_diffusion_dither_core.sv
